FILE: hdl/dvrt_pkg.sv
// Package for the distance-vector route table.
// Holds the shared constants, payload and command types, and helper functions.
// Depends on nothing else.
`timescale 1ns / 1ps

package dvrt_pkg;

    // Table size and saturation value.
    localparam int NODES = 4;
    localparam logic [16:0] UNREACHABLE = 17'd100000;
    localparam logic [2:0] DOWN_TICKS = 3'd3;
    localparam logic [2:0] SILENT_MAX = 3'd7;

    // Command queue between front and back; depth is a power of two.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [2:0] node_t;
    typedef logic [16:0] dist_t;
    typedef logic [NODES:0] nodeset_t;

    // Configuration register indexes.
    localparam logic CFG_OWN_NODE = 1'b0;
    localparam logic CFG_NEIGHBOR_MASK = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_LOOKUP,
        ACT_COST,
        ACT_VECTOR
    } action_t;

    typedef enum logic [2:0] {
        KIND_ADV,
        KIND_FWD,
        KIND_DELIV,
        KIND_UNR,
        KIND_UP,
        KIND_DOWN
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_EVT,
        ST_LOOK,
        ST_COST,
        ST_VEC1,
        ST_VEC2,
        ST_VEC3
    } state_t;

    // Input item as it arrives on the request channel.
    typedef struct packed {
        logic [1:0]  action;
        node_t       node_a;
        node_t       node_b;
        logic [15:0] link_cost;
        dist_t       advertised_distance;
    } req_t;

    // Result item on the response channel.
    typedef struct packed {
        logic [2:0] kind;
        node_t      peer;
        node_t      target;
        dist_t      distance;
        logic       last;
    } rsp_t;

    // Classified command held in the queue.
    typedef struct packed {
        action_t op;
        node_t   a;
        node_t   b;
        dist_t   value;
    } cmd_t;

    function automatic dist_t clip18(input logic [17:0] v);
        clip18 = (v > {1'b0, UNREACHABLE}) ? UNREACHABLE : v[16:0];
    endfunction

    function automatic dist_t sat_add(input dist_t a, input dist_t b);
        sat_add = clip18({1'b0, a} + {1'b0, b});
    endfunction

    function automatic logic valid_node(input node_t n);
        valid_node = (int'(n) >= 1) && (int'(n) <= NODES);
    endfunction

endpackage

FILE: hdl/dvrt_front.sv
// Front part of the route table: accepts input items, classifies them
// into commands and queues them for the back part. Uses dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dvrt_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_pop,
    output dvrt_pkg::cmd_t cmd
);
    import dvrt_pkg::*;

    cmd_t              q_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              cmd_in;
    logic              push;

    // Classify the item and clip its value to the saturation limit.
    always_comb
    begin
        cmd_in.op = action_t'(req.action);
        cmd_in.a  = req.node_a;
        cmd_in.b  = req.node_b;
        if (action_t'(req.action) == ACT_COST)
        begin
            cmd_in.value = clip18({2'b00, req.link_cost});
        end
        else
        begin
            cmd_in.value = clip18({1'b0, req.advertised_distance});
        end
    end

    assign req_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !(cmd_pop && cmd_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop && cmd_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: hdl/dvrt_back.sv
// Back part of the route table: holds the table state and configuration,
// carries out queued commands and drives the result register. Uses dvrt_pkg.
`timescale 1ns / 1ps

module dvrt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  dvrt_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dvrt_pkg::rsp_t rsp
);
    import dvrt_pkg::*;

    state_t     state_reg, state_next;
    node_t      own_reg, own_next;
    logic [3:0] mask_reg, mask_next;
    cmd_t       cmd_reg, cmd_next;
    node_t      nbr_reg, nbr_next;
    node_t      dst_reg, dst_next;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    dist_t rd_reg [0:NODES];
    dist_t rd_next [0:NODES];
    node_t nh_reg [0:NODES];
    node_t nh_next [0:NODES];
    dist_t nc_reg [0:NODES];
    dist_t nc_next [0:NODES];
    dist_t sv_reg [0:NODES];
    dist_t sv_next [0:NODES];
    logic [2:0] sil_reg [0:NODES];
    logic [2:0] sil_next [0:NODES];
    logic [2:0] pri_reg [0:NODES];
    logic [2:0] pri_next [0:NODES];

    logic     slot_free;
    logic     emit;
    rsp_t     emit_rsp;
    nodeset_t elig;
    node_t    first_nbr;
    node_t    later_nbr;
    logic     up_c;
    logic     down_c;
    logic [2:0] sil_inc;
    node_t    dest;
    dist_t    via;

    // Neighbors that a tick serves.
    function automatic nodeset_t eligible(input logic [3:0] mask, input node_t own);
        nodeset_t e;
        e = '0;
        for (int n = 1; n <= NODES; n++)
        begin
            e[n] = (n <= 4) && (((mask >> (n - 1)) & 4'd1) != 4'd0)
                   && (node_t'(n) != own);
        end
        eligible = e;
    endfunction

    // Lowest served neighbor above a given node, zero when none.
    function automatic node_t next_after(input nodeset_t e, input node_t after);
        node_t r;
        r = '0;
        for (int n = NODES; n >= 1; n--)
        begin
            if (e[n] && (node_t'(n) > after))
            begin
                r = node_t'(n);
            end
        end
        next_after = r;
    endfunction

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign elig      = eligible(mask_reg, own_reg);
    assign first_nbr = next_after(elig, '0);
    assign later_nbr = next_after(elig, nbr_reg);
    assign sil_inc   = (sil_reg[nbr_reg] < SILENT_MAX) ? sil_reg[nbr_reg] + 3'd1
                                                       : sil_reg[nbr_reg];
    assign up_c      = (pri_reg[nbr_reg] >= DOWN_TICKS) && (sil_reg[nbr_reg] == 3'd0);
    assign down_c    = (sil_inc == DOWN_TICKS);
    assign dest      = (cmd_reg.a == own_reg) ? cmd_reg.b : cmd_reg.a;

    // Sequencer and table update.
    always_comb
    begin
        state_next = state_reg;
        own_next   = own_reg;
        mask_next  = mask_reg;
        cmd_next   = cmd_reg;
        nbr_next   = nbr_reg;
        dst_next   = dst_reg;
        rd_next    = rd_reg;
        nh_next    = nh_reg;
        nc_next    = nc_reg;
        sv_next    = sv_reg;
        sil_next   = sil_reg;
        pri_next   = pri_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        emit_rsp   = '0;
        via        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        ACT_TICK:
                        begin
                            if (first_nbr != '0)
                            begin
                                nbr_next   = first_nbr;
                                dst_next   = node_t'(1);
                                state_next = ST_ADV;
                            end
                        end
                        ACT_LOOKUP: state_next = ST_LOOK;
                        ACT_COST:   state_next = ST_COST;
                        ACT_VECTOR: state_next = ST_VEC1;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end

            // One advertise entry per destination.
            ST_ADV:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_rsp.kind   = KIND_ADV;
                    emit_rsp.peer   = nbr_reg;
                    emit_rsp.target = dst_reg;
                    emit_rsp.distance = rd_reg[dst_reg];
                    emit_rsp.last   = (dst_reg == node_t'(NODES)) && !up_c && !down_c
                                      && (later_nbr == '0);
                    if (dst_reg == node_t'(NODES))
                    begin
                        state_next = ST_EVT;
                    end
                    else
                    begin
                        dst_next = dst_reg + 3'd1;
                    end
                end
            end

            // Neighbor up, aging and neighbor down.
            ST_EVT:
            begin
                if (slot_free)
                begin
                    if (up_c)
                    begin
                        nc_next[nbr_reg] = sv_reg[nbr_reg];
                        if (nh_reg[nbr_reg] == nbr_reg)
                        begin
                            rd_next[nbr_reg] = sv_reg[nbr_reg];
                        end
                        emit              = 1'b1;
                        emit_rsp.kind     = KIND_UP;
                        emit_rsp.peer     = nbr_reg;
                        emit_rsp.target   = nbr_reg;
                        emit_rsp.distance = sv_reg[nbr_reg];
                        emit_rsp.last     = (later_nbr == '0);
                    end
                    pri_next[nbr_reg] = sil_reg[nbr_reg];
                    sil_next[nbr_reg] = sil_inc;
                    if (down_c)
                    begin
                        sv_next[nbr_reg] = nc_reg[nbr_reg];
                        nc_next[nbr_reg] = UNREACHABLE;
                        for (int d = 1; d <= NODES; d++)
                        begin
                            if (((node_t'(d) == nbr_reg) || (node_t'(d) != own_reg))
                                && (nh_reg[d] == nbr_reg))
                            begin
                                rd_next[d] = UNREACHABLE;
                            end
                        end
                        emit              = 1'b1;
                        emit_rsp.kind     = KIND_DOWN;
                        emit_rsp.peer     = nbr_reg;
                        emit_rsp.target   = nbr_reg;
                        emit_rsp.distance = UNREACHABLE;
                        emit_rsp.last     = (later_nbr == '0);
                    end
                    if (later_nbr != '0)
                    begin
                        nbr_next   = later_nbr;
                        dst_next   = node_t'(1);
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Route lookup gives a single result.
            ST_LOOK:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_rsp.target = cmd_reg.a;
                    emit_rsp.peer   = '0;
                    emit_rsp.last   = 1'b1;
                    if (cmd_reg.a == own_reg)
                    begin
                        emit_rsp.kind     = KIND_DELIV;
                        emit_rsp.distance = valid_node(cmd_reg.a) ? rd_reg[cmd_reg.a] : '0;
                    end
                    else if (!valid_node(cmd_reg.a))
                    begin
                        emit_rsp.kind     = KIND_UNR;
                        emit_rsp.distance = UNREACHABLE;
                    end
                    else if (rd_reg[cmd_reg.a] < UNREACHABLE)
                    begin
                        emit_rsp.kind     = KIND_FWD;
                        emit_rsp.peer     = nh_reg[cmd_reg.a];
                        emit_rsp.distance = rd_reg[cmd_reg.a];
                    end
                    else
                    begin
                        emit_rsp.kind     = KIND_UNR;
                        emit_rsp.distance = rd_reg[cmd_reg.a];
                    end
                    state_next = ST_IDLE;
                end
            end

            // Direct link cost change.
            ST_COST:
            begin
                if (valid_node(dest))
                begin
                    if (nh_reg[dest] == dest)
                    begin
                        rd_next[dest] = cmd_reg.value;
                        nc_next[dest] = cmd_reg.value;
                    end
                    else if (rd_reg[dest] > cmd_reg.value)
                    begin
                        rd_next[dest] = cmd_reg.value;
                        nh_next[dest] = dest;
                        nc_next[dest] = cmd_reg.value;
                    end
                end
                state_next = ST_IDLE;
            end

            // Vector entry: refresh the neighbor and the route it owns.
            ST_VEC1:
            begin
                state_next = ST_IDLE;
                if (valid_node(cmd_reg.a))
                begin
                    sil_next[cmd_reg.a] = 3'd0;
                    if (valid_node(cmd_reg.b) && (cmd_reg.b != own_reg))
                    begin
                        if (nh_reg[cmd_reg.b] == cmd_reg.a)
                        begin
                            rd_next[cmd_reg.b] = sat_add(nc_reg[cmd_reg.a], cmd_reg.value);
                        end
                        state_next = ST_VEC2;
                    end
                end
            end

            // Vector entry: relax through the advertiser's route.
            ST_VEC2:
            begin
                via = sat_add(rd_reg[cmd_reg.a], cmd_reg.value);
                if (rd_reg[cmd_reg.b] > via)
                begin
                    rd_next[cmd_reg.b] = via;
                    nh_next[cmd_reg.b] = nh_reg[cmd_reg.a];
                end
                state_next = ST_VEC3;
            end

            // Vector entry: a direct link may still be shorter.
            ST_VEC3:
            begin
                if (rd_reg[cmd_reg.b] > nc_reg[cmd_reg.b])
                begin
                    rd_next[cmd_reg.b] = nc_reg[cmd_reg.b];
                    nh_next[cmd_reg.b] = cmd_reg.b;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes; a new own node restarts the table.
        if (cfg_we)
        begin
            if (cfg_index == CFG_OWN_NODE)
            begin
                own_next = cfg_data[2:0];
                for (int n = 0; n <= NODES; n++)
                begin
                    if ((n >= 1) && (node_t'(n) == cfg_data[2:0]))
                    begin
                        rd_next[n] = '0;
                        nh_next[n] = node_t'(n);
                        nc_next[n] = '0;
                    end
                    else
                    begin
                        rd_next[n] = UNREACHABLE;
                        nh_next[n] = '0;
                        nc_next[n] = UNREACHABLE;
                    end
                    sv_next[n]  = '0;
                    sil_next[n] = '0;
                    pri_next[n] = '0;
                end
            end
            else
            begin
                mask_next = cfg_data;
            end
        end
    end

    // State, configuration and table registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            own_reg       <= node_t'(1);
            mask_reg      <= '0;
            nbr_reg       <= node_t'(1);
            dst_reg       <= node_t'(1);
            rsp_valid_reg <= 1'b0;
            for (int n = 0; n <= NODES; n++)
            begin
                rd_reg[n]  <= (n == 1) ? '0 : UNREACHABLE;
                nh_reg[n]  <= (n == 1) ? node_t'(1) : '0;
                nc_reg[n]  <= (n == 1) ? '0 : UNREACHABLE;
                sv_reg[n]  <= '0;
                sil_reg[n] <= '0;
                pri_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            own_reg   <= own_next;
            mask_reg  <= mask_next;
            nbr_reg   <= nbr_next;
            dst_reg   <= dst_next;
            rd_reg    <= rd_next;
            nh_reg    <= nh_next;
            nc_reg    <= nc_next;
            sv_reg    <= sv_next;
            sil_reg   <= sil_next;
            pri_reg   <= pri_next;
            if (slot_free)
            begin
                rsp_valid_reg <= emit;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (slot_free && emit)
        begin
            rsp_reg <= emit_rsp;
        end
    end

endmodule

FILE: hdl/distance_vector_route_table.sv
// Top level of the distance-vector route table.
// Joins the front (dvrt_front) and back (dvrt_back) parts; uses dvrt_pkg.
//
// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_stall  dvrt_pkg::req_t
// rsp        out        rsp_valid/rsp_stall  dvrt_pkg::rsp_t
// cfg        in         cfg_we               cfg_index, cfg_data
//
// The front queues up to two items; the back runs one at a time. After the
// pop, a lookup runs ST_LOOK, a cost change ST_COST, a vector entry ST_VEC1
// (then ST_VEC2 and ST_VEC3 for a valid target), a tick ST_ADV and ST_EVT
// per served neighbor (one result a cycle unless stalled). Reset clears the
// table to its own-node-1 start; stalled results hold the register and emits wait.
`timescale 1ns / 1ps

module distance_vector_route_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dvrt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dvrt_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data
);
    import dvrt_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // Intake and classification.
    dvrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Table and execution.
    dvrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
